// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the duration statistics RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define DSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never occurs outside reset.
`define DSC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DSC_ASSERT(lbl, clk, rst, prop, msg)
`define DSC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/dsc_pkg.sv =====
// Types and constants for the duration statistics collector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package dsc_pkg;

  localparam int CAT_W      = 3;
  localparam int DUR_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int US_W       = 32;
  localparam int FRAC_W     = 10;
  localparam int US_SCALE   = 1000;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  // positive magnitude (31 bits) times 1000 fits in 41 bits
  localparam int PROD_W     = DUR_W - 1 + FRAC_W;
  localparam int CMDQ_DEPTH = 4;

  // command word passed from the front to the back
  typedef struct packed {
    logic             take;
    logic [CAT_W-1:0] category;
    logic [US_W-1:0]  us;
  } cmd_t;

  // one category result word
  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [US_W-1:0]    max_us;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/dsc_front.sv =====
// Front end: classifies input words and converts durations to microseconds.
// Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dsc_front #(
  parameter int NUM_CATEGORIES = 6
) (
  input  logic                               push,
  input  logic                               full,
  input  logic                               action,
  input  logic [dsc_pkg::CAT_W-1:0]          category,
  input  logic signed [dsc_pkg::DUR_W-1:0]   duration_ms_q10,
  output logic                               wr,
  output dsc_pkg::cmd_t                      cmd
);
  import dsc_pkg::*;

  logic              cat_ok;
  logic              positive;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;

  // drop records aimed at a category that does not exist
  assign cat_ok = 32'(category) < 32'(NUM_CATEGORIES);

  // round d*1000/1024 half up; zero or negative gives zero
  assign positive = !duration_ms_q10[DUR_W-1] && (duration_ms_q10 != '0);
  assign prod     = PROD_W'(duration_ms_q10[DUR_W-2:0]) * PROD_W'(US_SCALE);
  assign rounded  = prod + PROD_W'(ROUND_HALF);

  always_comb begin
    cmd.take     = action;
    cmd.category = category;
    cmd.us       = positive ? US_W'(rounded[PROD_W-1:FRAC_W]) : '0;
    wr           = push && !full && (action || cat_ok);
  end

endmodule
`default_nettype wire

// ===== rtl/dsc_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on dsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dsc_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dsc_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output dsc_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import dsc_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count == CNT_W'(CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = slots[rd_ptr];

  // store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `DSC_ASSERT(a_cnt_bound, clk, rst, (count <= CNT_W'(CMDQ_DEPTH)), "queue count overflow")
  `DSC_ASSERT(a_cnt_up, clk, rst, (do_wr && !do_rd) |=> (count == $past(count) + 1'b1), "queue count missed write")
  `DSC_ASSERT(a_cnt_dn, clk, rst, (do_rd && !do_wr) |=> (count == $past(count) - 1'b1), "queue count missed read")

endmodule
`default_nettype wire

// ===== rtl/dsc_back.sv =====
// Back end: applies records to the statistics registers and streams snapshots.
// Depends on dsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dsc_back #(
  parameter int NUM_CATEGORIES = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  dsc_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  output dsc_pkg::result_t out_res,
  input  logic             out_pop
);
  import dsc_pkg::*;

  localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int EXT_W = (IDX_W > CAT_W) ? IDX_W : CAT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CATEGORIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TAKE = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   idx;
  logic [COUNT_W-1:0] count_store [NUM_CATEGORIES];
  logic [TOTAL_W-1:0] total_store [NUM_CATEGORIES];
  logic [US_W-1:0]    max_store   [NUM_CATEGORIES];

  logic [EXT_W-1:0]   cat_ext;
  logic [EXT_W-1:0]   idx_ext;
  logic [IDX_W-1:0]   addr;
  logic [COUNT_W-1:0] cnt_rd;
  logic [TOTAL_W-1:0] tot_rd;
  logic [US_W-1:0]    max_rd;
  logic [COUNT_W-1:0] cnt_upd;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_upd;
  logic [US_W-1:0]    max_upd;
  logic               slot_free;
  logic               emit;
  logic               do_rec;

  // select the entry: snapshot index while taking, else the record's category
  assign cat_ext = EXT_W'(cmd.category);
  assign idx_ext = EXT_W'(idx);
  assign addr    = (state == ST_TAKE) ? idx : cat_ext[IDX_W-1:0];
  assign cnt_rd  = count_store[addr];
  assign tot_rd  = total_store[addr];
  assign max_rd  = max_store[addr];

  // saturating count and total, running maximum
  assign cnt_upd = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
  assign tot_sum = {1'b0, tot_rd} + (TOTAL_W + 1)'(cmd.us);
  assign tot_upd = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
  assign max_upd = (cmd.us > max_rd) ? cmd.us : max_rd;

  assign slot_free = !out_valid || out_pop;
  assign emit      = (state == ST_TAKE) && slot_free;
  assign do_rec    = (state == ST_IDLE) && cmd_valid && !cmd.take;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  // sequence: idle takes words, take walks every category
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.take) begin
          state_next = ST_TAKE;
        end
      end
      ST_TAKE: begin
        if (emit && (idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.take) begin
        idx <= '0;
      end else if (emit) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
  end

  // update on record, clear each entry as it is reported
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        count_store[i] <= '0;
        total_store[i] <= '0;
        max_store[i]   <= '0;
      end
    end else if (do_rec) begin
      count_store[addr] <= cnt_upd;
      total_store[addr] <= tot_upd;
      max_store[addr]   <= max_upd;
    end else if (emit) begin
      count_store[addr] <= '0;
      total_store[addr] <= '0;
      max_store[addr]   <= '0;
    end
  end

  // hold result word until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res.category <= idx_ext[CAT_W-1:0];
      out_res.count    <= cnt_rd;
      out_res.total    <= tot_rd;
      out_res.max_us   <= max_rd;
      out_res.last     <= (idx == LAST_IDX);
    end
  end

  `DSC_NEVER(a_no_pop_take, clk, rst, (state == ST_TAKE) && cmd_pop, "queue popped during snapshot")
  `DSC_ASSERT(a_last_idle, clk, rst, (emit && (idx == LAST_IDX)) |=> (state == ST_IDLE), "snapshot did not end")
  `DSC_ASSERT(a_cleared, clk, rst, emit |=> (count_store[$past(idx)] == '0), "reported entry not cleared")
  `DSC_ASSERT(a_last_flag, clk, rst, emit |=> (out_res.last == ($past(idx) == LAST_IDX)), "last flag wrong")

endmodule
`default_nettype wire

// ===== rtl/duration_stats_collector.sv =====
// Per-category duration statistics: records accepted one per cycle unless the
// queue is full, retired one per cycle by the back end; a take holds the back
// end as it walks every category (longer under output stall). Rate is set by
// the 4-word command queue and the single result register. Reset (synchronous,
// active high) clears all statistics, queue and output. Depends on dsc_pkg,
// dsc_front, dsc_cmd_fifo and dsc_back.
`timescale 1ns / 1ps
`default_nettype none
module duration_stats_collector #(
  parameter int NUM_CATEGORIES = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             action,
  input  logic [dsc_pkg::CAT_W-1:0]        category,
  input  logic signed [dsc_pkg::DUR_W-1:0] duration_ms_q10,
  output logic                             empty,
  input  logic                             pop,
  output logic [dsc_pkg::CAT_W-1:0]        out_category,
  output logic [dsc_pkg::COUNT_W-1:0]      event_count,
  output logic [dsc_pkg::TOTAL_W-1:0]      total_time_us,
  output logic [dsc_pkg::US_W-1:0]         max_time_us,
  output logic                             last
);
  import dsc_pkg::*;

  logic    q_wr;
  cmd_t    q_wr_cmd;
  logic    q_rd;
  cmd_t    q_rd_cmd;
  logic    q_empty;
  logic    out_valid;
  result_t out_res;

  dsc_front #(
    .NUM_CATEGORIES(NUM_CATEGORIES)
  ) u_front (
    .push           (push),
    .full           (full),
    .action         (action),
    .category       (category),
    .duration_ms_q10(duration_ms_q10),
    .wr             (q_wr),
    .cmd            (q_wr_cmd)
  );

  dsc_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wr_cmd(q_wr_cmd),
    .full  (full),
    .rd    (q_rd),
    .rd_cmd(q_rd_cmd),
    .empty (q_empty)
  );

  dsc_back #(
    .NUM_CATEGORIES(NUM_CATEGORIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!q_empty),
    .cmd      (q_rd_cmd),
    .cmd_pop  (q_rd),
    .out_valid(out_valid),
    .out_res  (out_res),
    .out_pop  (pop && out_valid)
  );

  // present the waiting result word
  assign empty         = !out_valid;
  assign out_category  = out_res.category;
  assign event_count   = out_res.count;
  assign total_time_us = out_res.total;
  assign max_time_us   = out_res.max_us;
  assign last          = out_res.last;

endmodule
`default_nettype wire

// ===== test/tb_duration_stats_collector.sv =====
// Self-checking testbench for duration_stats_collector: directed table and
// random record/take traffic with bursty push and stalled pop.
// Depends on dsc_pkg and the duration_stats_collector RTL.
`timescale 1ns / 1ps
module tb_duration_stats_collector;
  import dsc_pkg::*;

  localparam int NUM_CAT = 6;
  localparam logic [COUNT_W-1:0] COUNT_ALL = '1;
  localparam longint unsigned TOTAL_ALL = 64'h0000_FFFF_FFFF_FFFF;
  localparam int RANDOM_WORDS = 240;

  typedef enum logic {ACT_RECORD = 1'b0, ACT_TAKE = 1'b1} act_t;

  // one input word, with an optional hand-typed result for one category
  typedef struct {
    act_t                    op;
    logic [CAT_W-1:0]        cat;
    logic signed [DUR_W-1:0] dur;
    bit                      typed;
    logic [CAT_W-1:0]        t_cat;
    logic [COUNT_W-1:0]      t_count;
    logic [TOTAL_W-1:0]      t_total;
    logic [US_W-1:0]         t_max;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    action = 1'b0;
  logic [CAT_W-1:0]        category = '0;
  logic signed [DUR_W-1:0] duration_ms_q10 = '0;
  logic                    pop = 1'b0;
  logic                    full;
  logic                    empty;
  logic [CAT_W-1:0]        out_category;
  logic [COUNT_W-1:0]      event_count;
  logic [TOTAL_W-1:0]      total_time_us;
  logic [US_W-1:0]         max_time_us;
  logic                    last;

  // predicted statistics and the snapshot words still owed by the block
  logic [COUNT_W-1:0] cnt_st  [NUM_CAT];
  logic [TOTAL_W-1:0] sum_st  [NUM_CAT];
  logic [US_W-1:0]    peak_st [NUM_CAT];
  result_t            snapshot_q [$];
  result_t            want_word;
  int                 errors = 0;
  int                 burst_left = 0;
  int                 stall_mode = 0;
  int                 stall_left = 0;

  step_t plan [21] = '{
    '{ACT_TAKE,   3'd0, 32'sh0000_0000, 1'b1, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd0, 32'sh0000_0000, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd0, 32'shFFFF_FFFF, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd0, 32'sh8000_0000, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd0, 32'sh0000_0001, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_TAKE,   3'd7, 32'shFFFF_FFFF, 1'b1, 3'd0, 32'd4, 48'd1, 32'd1},
    '{ACT_RECORD, 3'd1, 32'sh7FFF_FFFF, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd1, 32'sh7FFF_FFFF, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_TAKE,   3'd0, 32'sh0000_0000, 1'b1, 3'd1, 32'd2, 48'd4194303998,
      32'd2097151999},
    '{ACT_RECORD, 3'd6, 32'sh0000_0400, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd7, 32'sh7FFF_FFFF, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_TAKE,   3'd5, 32'sh0000_0000, 1'b1, 3'd5, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd2, 32'sh0000_0400, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd2, 32'sh0000_0040, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd3, 32'sh5555_5555, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd4, 32'sh2AAA_AAAA, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd5, 32'sh0000_0400, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd5, 32'shFFFF_FC00, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_RECORD, 3'd3, 32'sh0000_0001, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0},
    '{ACT_TAKE,   3'd2, 32'sh1234_5678, 1'b1, 3'd2, 32'd2, 48'd1063, 32'd1000},
    '{ACT_RECORD, 3'd5, 32'sh7FFF_FFFF, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0}
  };

  duration_stats_collector #(.NUM_CATEGORIES(NUM_CAT)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .category(category), .duration_ms_q10(duration_ms_q10), .empty(empty),
    .pop(pop), .out_category(out_category), .event_count(event_count),
    .total_time_us(total_time_us), .max_time_us(max_time_us), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // convert a Q21.10 millisecond value to whole microseconds, half rounds up
  function automatic longint unsigned q10_to_us(input logic signed [DUR_W-1:0] d);
    if (d <= 0) return 0;
    return (longint'(d) * US_SCALE + ROUND_HALF) >> FRAC_W;
  endfunction

  // advance the predicted statistics by one accepted word
  function automatic void stats_apply(input step_t s);
    longint unsigned us;
    longint unsigned sum;
    result_t r;
    int i;
    if (s.op == ACT_RECORD) begin
      if (s.cat >= NUM_CAT) return;
      us = q10_to_us(s.dur);
      if (cnt_st[s.cat] != COUNT_ALL) cnt_st[s.cat] = cnt_st[s.cat] + 1'b1;
      sum = longint'(sum_st[s.cat]) + us;
      sum_st[s.cat] = (sum > TOTAL_ALL) ? TOTAL_ALL[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
      if (us > peak_st[s.cat]) peak_st[s.cat] = us[US_W-1:0];
    end else begin
      for (i = 0; i < NUM_CAT; i++) begin
        r.category = i[CAT_W-1:0];
        r.count    = cnt_st[i];
        r.total    = sum_st[i];
        r.max_us   = peak_st[i];
        r.last     = (i == NUM_CAT - 1);
        if (s.typed && s.t_cat == i) begin
          r.count  = s.t_count;
          r.total  = s.t_total;
          r.max_us = s.t_max;
        end
        snapshot_q.push_back(r);
        cnt_st[i]  = '0;
        sum_st[i]  = '0;
        peak_st[i] = '0;
      end
    end
  endfunction

  // present one word and hold it until the block takes it
  task automatic put_word(input step_t s);
    push            <= 1'b1;
    action          <= s.op;
    category        <= s.cat;
    duration_ms_q10 <= s.dur;
    @(posedge clk);
    while (full) @(posedge clk);
    stats_apply(s);
  endtask

  // drop push for a random gap once the current burst is used up
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // draw a random duration, weighted toward the conversion corners
  function automatic logic signed [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $signed(32'h8000_0000 | $urandom());
      2: return 32'sh7FFF_FFFF;
      3: return $urandom_range(1, 4096);
      4: return 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // receiver: stall on a pattern whose mode is redrawn when its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= 1'b0;
    endcase
  end

  // check each popped result word against the oldest snapshot word owed
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (snapshot_q.size() == 0) begin
        $display("%0t: result word with nothing expected, category %0d", $time,
                 out_category);
        errors++;
      end else begin
        want_word = snapshot_q.pop_front();
        if (out_category !== want_word.category) begin
          $display("%0t: out_category expected %0d got %0d", $time,
                   want_word.category, out_category);
          errors++;
        end
        if (event_count !== want_word.count) begin
          $display("%0t: event_count cat %0d expected %0d got %0d", $time,
                   want_word.category, want_word.count, event_count);
          errors++;
        end
        if (total_time_us !== want_word.total) begin
          $display("%0t: total_time_us cat %0d expected %0d got %0d", $time,
                   want_word.category, want_word.total, total_time_us);
          errors++;
        end
        if (max_time_us !== want_word.max_us) begin
          $display("%0t: max_time_us cat %0d expected %0d got %0d", $time,
                   want_word.category, want_word.max_us, max_time_us);
          errors++;
        end
        if (last !== want_word.last) begin
          $display("%0t: last cat %0d expected %0b got %0b", $time,
                   want_word.category, want_word.last, last);
          errors++;
        end
      end
    end
  end

  // stop a hung run
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    step_t s;
    int valid;
    int i;
    for (i = 0; i < NUM_CAT; i++) begin
      cnt_st[i]  = '0;
      sum_st[i]  = '0;
      peak_st[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (plan[k]) begin
      pace();
      put_word(plan[k]);
    end

    // random records with occasional takes
    s = '{ACT_RECORD, 3'd0, 32'sh0000_0000, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0};
    valid = 0;
    while (valid < RANDOM_WORDS) begin
      s.op    = ($urandom_range(0, 8) == 0) ? ACT_TAKE : ACT_RECORD;
      s.cat   = ($urandom_range(0, 15) == 0) ? CAT_W'($urandom_range(6, 7))
                                             : CAT_W'($urandom_range(0, NUM_CAT - 1));
      s.dur   = pick_duration();
      s.typed = 1'b0;
      pace();
      put_word(s);
      if (s.op == ACT_TAKE || s.cat < NUM_CAT) valid++;
    end
    s = '{ACT_TAKE, 3'd0, 32'sh0000_0000, 1'b0, 3'd0, 32'd0, 48'd0, 32'd0};
    put_word(s);
    push <= 1'b0;

    // drain, then watch a while for stray words
    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
